// ----- sv/msp_pkg.sv -----
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants for the exact maximum prefix sum unit
// Item structs, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

  localparam logic [63:0] EXP_INF      = 64'h7FF0_0000_0000_0000;
  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

  typedef struct packed {
    logic [63:0] value;
    logic        first;
  } in_item_t;

  typedef struct packed {
    logic [31:0] best_index;
    logic [63:0] best_rounded;
    logic [63:0] sum_rounded;
    logic        invalid_seen;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_NLOAD,
    ST_NORM,
    ST_ROUND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic norm_load;
    logic norm_step;
    logic round;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_bad;
    logic last_limb;
    logic norm_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- sv/msp_scan.sv -----
// ----------------------------------------------------------------------------
// msp_scan: leading limb tracker
// Watches a limb stream, least significant first, and keeps the highest
// non-zero limb, the limb below it and a sticky OR of everything lower.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_scan #(
  parameter int HW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clear,
  input  wire logic          step,
  input  wire logic [HW-1:0] idx,
  input  wire logic [63:0]   limb,
  output logic               found,
  output logic [HW-1:0]      h,
  output logic [63:0]        vh,
  output logic [63:0]        vl,
  output logic               st
);

  logic [63:0] prev;
  logic        lowor;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found <= 1'b0;
      prev  <= '0;
      lowor <= 1'b0;
      st    <= 1'b0;
    end else if (step) begin
      if (limb != '0) begin
        found <= 1'b1;
        h     <= idx;
        vh    <= limb;
        vl    <= prev;
        st    <= lowor;
      end
      lowor <= lowor | (prev != '0);
      prev  <= limb;
    end
  end

endmodule

`default_nettype wire

// ----- sv/msp_norm.sv -----
// ----------------------------------------------------------------------------
// msp_norm: iterative left normaliser
// Shifts a 128-bit word left by eight or by one per cycle while step is high
// and until its top bit is set, counting the leading zeros on the way.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_norm (
  input  wire logic         clk,
  input  wire logic         load,
  input  wire logic [127:0] load_w,
  input  wire logic         step,
  output logic [127:0]      w,
  output logic [6:0]        lz,
  output logic              done
);

  assign done = w[127];

  always_ff @(posedge clk) begin
    if (load) begin
      w  <= load_w;
      lz <= '0;
    end else if (step && !w[127]) begin
      if (w[127:120] == 8'h00) begin
        w  <= {w[119:0], 8'h00};
        lz <= lz + 7'd8;
      end else begin
        w  <= {w[126:0], 1'b0};
        lz <= lz + 7'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/msp_datapath.sv -----
// ----------------------------------------------------------------------------
// msp_datapath: accumulators, compare, rounding and output register
// Two rotating limb rings hold the running sum and the best prefix sum. One
// pass adds the input, compares and scans both values for rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_datapath
  import msp_pkg::*;
#(
  parameter int LIMBS      = 34,
  parameter int INDEX_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cmd_t      cmd,
  output status_t        status,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int HW = $clog2(LIMBS);
  localparam int PW = HW + 6;

  logic [63:0]           run_acc [LIMBS];
  logic [63:0]           best_acc [LIMBS];
  logic                  pend;
  logic [63:0]           val;
  logic [63:0]           p0, p1;
  logic [4:0]            q;
  logic                  neg_in;
  logic                  carry;
  logic                  ge;
  logic [HW-1:0]         limb;
  logic                  nc_s, nc_b;
  logic                  sign_s, sign_b;
  logic [INDEX_BITS-1:0] count, idx, best_pos;
  logic                  bad;
  logic [63:0]           best_r, sum_r;

  // Per-limb arithmetic.
  logic [63:0]  head_r, head_b, t, new_limb, ns, nb, xc, yc;
  logic [64:0]  sum65;
  logic         is_top;
  logic [10:0]  e;
  logic [52:0]  m;
  logic [10:0]  sh;
  logic [127:0] wide;

  assign status.in_bad    = (in_data.value[62:52] == EXP_ALL_ONES);
  assign status.last_limb = (limb == HW'(LIMBS - 1));

  always_comb begin
    e    = val[62:52];
    m    = (e == '0) ? {1'b0, val[51:0]} : {1'b1, val[51:0]};
    sh   = (e == '0) ? 11'd0 : e - 11'd1;
    wide = {75'd0, m} << sh[5:0];
  end

  always_comb begin
    head_r = run_acc[0];
    head_b = pend ? run_acc[0] : best_acc[0];
    if (limb == HW'(q)) begin
      t = p0;
    end else if (limb == HW'(q) + HW'(1)) begin
      t = p1;
    end else begin
      t = '0;
    end
    if (neg_in) begin
      sum65 = {1'b0, head_r} - {1'b0, t} - {64'd0, carry};
    end else begin
      sum65 = {1'b0, head_r} + {1'b0, t} + {64'd0, carry};
    end
    new_limb = sum65[63:0];
    is_top   = status.last_limb;
    xc       = {new_limb[63] ^ is_top, new_limb[62:0]};
    yc       = {head_b[63] ^ is_top, head_b[62:0]};
    ns       = ~new_limb + {63'd0, nc_s};
    nb       = ~head_b + {63'd0, nc_b};
  end

  // Leading limb trackers: positive and negated views of both values.
  logic          fnd [4];
  logic [HW-1:0] hh [4];
  logic [63:0]   vvh [4];
  logic [63:0]   vvl [4];
  logic          sst [4];
  logic [63:0]   feed [4];

  assign feed[0] = new_limb;
  assign feed[1] = ns;
  assign feed[2] = head_b;
  assign feed[3] = nb;

  for (genvar g = 0; g < 4; g++) begin : g_scan
    msp_scan #(.HW(HW)) u_scan (
      .clk   (clk),
      .rst   (rst),
      .clear (cmd.setup),
      .step  (cmd.step),
      .idx   (limb),
      .limb  (feed[g]),
      .found (fnd[g]),
      .h     (hh[g]),
      .vh    (vvh[g]),
      .vl    (vvl[g]),
      .st    (sst[g])
    );
  end

  // Pick the magnitude view by sign.
  logic          f_s, f_b, st_s, st_b;
  logic [HW-1:0] h_s, h_b;
  logic [63:0]   vh_s, vh_b, vl_s, vl_b;

  always_comb begin
    f_s  = sign_s ? fnd[1] : fnd[0];
    h_s  = sign_s ? hh[1]  : hh[0];
    vh_s = sign_s ? vvh[1] : vvh[0];
    vl_s = sign_s ? vvl[1] : vvl[0];
    st_s = sign_s ? sst[1] : sst[0];
    f_b  = sign_b ? fnd[3] : fnd[2];
    h_b  = sign_b ? hh[3]  : hh[2];
    vh_b = sign_b ? vvh[3] : vvh[2];
    vl_b = sign_b ? vvl[3] : vvl[2];
    st_b = sign_b ? sst[3] : sst[2];
  end

  logic [127:0] w_s, w_b;
  logic [6:0]   lz_s, lz_b;
  logic         d_s, d_b;

  msp_norm u_norm_s (
    .clk    (clk),
    .load   (cmd.norm_load),
    .load_w (f_s ? {vh_s, vl_s} : {1'b1, 127'd0}),
    .step   (cmd.norm_step),
    .w      (w_s),
    .lz     (lz_s),
    .done   (d_s)
  );

  msp_norm u_norm_b (
    .clk    (clk),
    .load   (cmd.norm_load),
    .load_w (f_b ? {vh_b, vl_b} : {1'b1, 127'd0}),
    .step   (cmd.norm_step),
    .w      (w_b),
    .lz     (lz_b),
    .done   (d_b)
  );

  assign status.norm_done = d_s && d_b;
  assign status.out_free  = !out_valid || out_ready;

  function automatic logic [63:0] round_acc(
    input logic          sign,
    input logic          found,
    input logic [HW-1:0] h,
    input logic [6:0]    lz,
    input logic [127:0]  w,
    input logic          st,
    input logic [63:0]   vh
  );
    logic [PW-1:0] p;
    logic [PW-1:0] shf;
    logic          up;
    logic [63:0]   bits;
    p   = {h, 6'(7'd63 - lz)};
    shf = p - PW'(52);
    up  = w[74] && ((|w[73:0]) || st || w[75]);
    bits = {1'b0, shf[10:0], 52'd0} + {11'd0, w[127:75]} + {63'd0, up};
    if (!found) begin
      round_acc = '0;
    end else if (h == '0 && lz >= 7'd11) begin
      round_acc = {sign, vh[62:0]};
    end else if (p >= PW'(2098)) begin
      round_acc = {sign, EXP_INF[62:0]};
    end else if (bits >= EXP_INF) begin
      round_acc = {sign, EXP_INF[62:0]};
    end else begin
      round_acc = {sign, bits[62:0]};
    end
  endfunction

  logic [63:0] rs, rb;
  assign rs = round_acc(sign_s, f_s, h_s, lz_s, w_s, st_s, vh_s);
  assign rb = round_acc(sign_b, f_b, h_b, lz_b, w_b, st_b, vh_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LIMBS; i++) begin
        run_acc[i]  <= '0;
        best_acc[i] <= '0;
      end
      pend      <= 1'b0;
      count     <= '0;
      idx       <= '0;
      best_pos  <= '0;
      bad       <= 1'b0;
      best_r    <= '0;
      sum_r     <= '0;
      out_valid <= 1'b0;
      limb      <= '0;
      ge        <= 1'b1;
    end else begin
      if (cmd.load) begin
        val <= in_data.value;
        if (in_data.first) begin
          for (int i = 0; i < LIMBS; i++) begin
            run_acc[i]  <= '0;
            best_acc[i] <= '0;
          end
          pend     <= 1'b0;
          idx      <= '0;
          count    <= INDEX_BITS'(1);
          best_pos <= '0;
          bad      <= status.in_bad;
          best_r   <= '0;
          sum_r    <= '0;
        end else begin
          idx   <= count;
          count <= count + INDEX_BITS'(1);
          bad   <= bad | status.in_bad;
        end
      end
      if (cmd.setup) begin
        p0     <= wide[63:0];
        p1     <= wide[127:64];
        q      <= sh[10:6];
        neg_in <= val[63];
        limb   <= '0;
        carry  <= 1'b0;
        ge     <= 1'b1;
        nc_s   <= 1'b1;
        nc_b   <= 1'b1;
      end
      if (cmd.step) begin
        for (int i = 0; i < LIMBS - 1; i++) begin
          run_acc[i]  <= run_acc[i+1];
          best_acc[i] <= best_acc[i+1];
        end
        run_acc[LIMBS-1]  <= new_limb;
        best_acc[LIMBS-1] <= head_b;
        carry <= sum65[64];
        if (xc != yc) begin
          ge <= (xc > yc);
        end
        nc_s <= nc_s & (ns == '0);
        nc_b <= nc_b & (nb == '0);
        if (is_top) begin
          sign_s <= new_limb[63];
          sign_b <= head_b[63];
        end
        limb <= limb + HW'(1);
      end
      if (cmd.round) begin
        sum_r  <= rs;
        best_r <= ge ? rs : rb;
        pend   <= ge;
        if (ge) begin
          best_pos <= idx;
        end
      end
      if (cmd.emit) begin
        out_valid             <= 1'b1;
        out_data.best_index   <= 32'(best_pos);
        out_data.best_rounded <= best_r;
        out_data.sum_rounded  <= sum_r;
        out_data.invalid_seen <= bad;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/msp_ctrl.sv -----
// ----------------------------------------------------------------------------
// msp_ctrl: sequencing state machine
// Steps one item through set-up, the limb pass, normalising, rounding and
// hand-over to the output register; an infinity or NaN item skips to hand-over.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_ctrl
  import msp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_bad ? ST_EMIT : ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last_limb) begin
          state_next = ST_NLOAD;
        end
      end
      ST_NLOAD: begin
        cmd.norm_load = 1'b1;
        state_next    = ST_NORM;
      end
      ST_NORM: begin
        if (status.norm_done) begin
          state_next = ST_ROUND;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_ROUND: begin
        cmd.round  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/exact_max_prefix_sum_unit.sv -----
// ----------------------------------------------------------------------------
// exact_max_prefix_sum_unit: exact maximum prefix sum over IEEE doubles
// Adds each finite double exactly into a wide fixed-point accumulator and
// tracks the largest prefix sum, reporting both rounded to nearest double.
// ----------------------------------------------------------------------------
// Timing: a finite item passes set-up, the limb pass, the normaliser load,
// normalising, rounding and the emit state before its result is registered;
// an infinity or NaN item goes straight from acceptance to the emit state.
// Flow: one item at a time; the input reopens the cycle after the result
// is registered, and later while the output is stalled.
// Synchronous reset clears both accumulators, the index, the flag and out_valid.
`default_nettype none

module exact_max_prefix_sum_unit
  import msp_pkg::*;
#(
  parameter int LIMBS      = 34,
  parameter int INDEX_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  // The controller sequences each finite item: set-up computes the shifted
  // mantissa, the run pass walks every limb once (add, signed compare and
  // leading-limb scan of both values, with a deferred copy of the running
  // sum into the best ring), the normalisers find the leading one, and the
  // rounding step fixes both doubles before the item is handed to the
  // output register; an infinity or NaN item is handed over directly.
  cmd_t    cmd;
  status_t status;

  msp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds both accumulator rings, the index counters, the
  // sticky flag and the output register that decouples the result side.
  msp_datapath #(
    .LIMBS      (LIMBS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Only one command is issued in any cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.setup, cmd.step, cmd.norm_load, cmd.norm_step,
              cmd.round, cmd.emit}))
    else $error("more than one datapath command at once");

  // An item is loaded only when the input handshake completes.
  a_load_hs: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (in_valid && in_ready))
    else $error("item loaded without handshake");

  // A result never overwrites one that is still waiting.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result emitted into a full output register");

  // Rounding only follows completed normalisation.
  a_round_norm: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> status.norm_done)
    else $error("rounding before normalisation finished");

  // After an item is taken the input side is closed in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input reopened straight after acceptance");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for exact_max_prefix_sum_unit
// Feeds sequences of IEEE doubles, predicts the exact running and maximal
// prefix sums in a wide two's complement accumulator, and checks every
// result field against that prediction while both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
  import msp_pkg::*;

  localparam int LIMBS   = 34;
  localparam int ACC_W   = 64 * LIMBS;
  localparam int MAX_CYC = 2_000_000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  exact_max_prefix_sum_unit #(.LIMBS(LIMBS), .INDEX_BITS(32)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: the exact running sum, the best prefix sum so far,
  // its index, the item counter within the sequence and the sticky flag.
  logic [ACC_W-1:0] running_sum = '0;
  logic [ACC_W-1:0] best_sum    = '0;
  logic [31:0]      best_at     = '0;
  logic [31:0]      seq_index   = '0;
  logic             nonfinite   = 1'b0;

  in_item_t  pending_items[$];
  out_item_t awaited_results[$];
  int        n_errors  = 0;
  int        n_results = 0;
  int        n_nonfin  = 0;
  int        n_seqs    = 0;
  int        cycles    = 0;

  // Round a two's complement accumulator to the nearest double, ties to even.
  function automatic logic [63:0] round_to_double(logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] lowmask;
    logic             sgn;
    int               p;
    int               sh;
    logic [63:0]      mant;
    logic [63:0]      bits;
    sgn = acc[ACC_W-1];
    mag = sgn ? -acc : acc;
    p = -1;
    for (int i = ACC_W - 1; i >= 0; i--) begin
      if (mag[i]) begin
        p = i;
        break;
      end
    end
    if (p < 0) return 64'd0;
    if (p <= 52) return {sgn, mag[62:0]};
    sh = p - 52;
    if (sh >= 2046) return {sgn, EXP_INF[62:0]};
    mant = 64'(mag >> sh);
    lowmask = {ACC_W{1'b1}} >> (ACC_W - sh + 1);
    if (mag[sh-1] && ((|(mag & lowmask)) || mant[0])) mant = mant + 64'd1;
    bits = (64'(sh) << 52) + mant;
    if (bits >= EXP_INF) bits = EXP_INF;
    return {sgn, bits[62:0]};
  endfunction

  // Advance the prediction by one accepted item and queue the expected result.
  task automatic predict_prefix(in_item_t it);
    logic [ACC_W-1:0] term;
    logic [10:0]      ex;
    out_item_t        res;
    if (it.first) begin
      running_sum = '0;
      best_sum    = '0;
      best_at     = '0;
      seq_index   = '0;
      nonfinite   = 1'b0;
    end
    ex = it.value[62:52];
    if (ex == EXP_ALL_ONES) begin
      nonfinite = 1'b1;
    end else begin
      term = '0;
      term[51:0] = it.value[51:0];
      if (ex != 11'd0) begin
        term[52] = 1'b1;
        term = term << (ex - 11'd1);
      end
      running_sum = it.value[63] ? running_sum - term : running_sum + term;
      if ($signed(running_sum) >= $signed(best_sum)) begin
        best_sum = running_sum;
        best_at  = seq_index;
      end
    end
    seq_index = seq_index + 32'd1;
    res.best_index   = best_at;
    res.best_rounded = round_to_double(best_sum);
    res.sum_rounded  = round_to_double(running_sum);
    res.invalid_seen = nonfinite;
    awaited_results.push_back(res);
  endtask

  // Random doubles: mostly moderate magnitudes so that sums cancel and
  // compare closely, plus subnormals, huge values, zeros and non-finites.
  function automatic logic [63:0] random_double();
    int          pick;
    logic [63:0] v;
    pick = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    if (pick < 55)      v[62:52] = 11'($urandom_range(1000, 1050));
    else if (pick < 63) v[62:52] = 11'($urandom_range(0, 3));
    else if (pick < 70) v[62:52] = 11'($urandom_range(2030, 2046));
    else if (pick < 75) v[62:0]  = 63'd0;
    else if (pick < 80) begin
      v[62:52] = EXP_ALL_ONES;
      if ($urandom_range(0, 1) == 0) v[51:0] = 52'd0;
    end
    else if (pick < 85) v[62:52] = 11'($urandom_range(1020, 1024));
    return v;
  endfunction

  // Driver: bursts of random length separated by random gaps, valid held
  // until the item is taken.
  int burst_left = 1;
  int gap_left   = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_prefix(in_data);
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: the receiver stalls on its own slowly changing pattern and each
  // taken result is checked against the oldest expectation.
  int stall_mode = 0;
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (awaited_results.size() == 0) begin
          $error("result with no expectation waiting: %h", out_data);
          n_errors++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (out_data.best_index !== exp_res.best_index) begin
            $error("best_index expected %0d got %0d", exp_res.best_index,
                   out_data.best_index);
            n_errors++;
          end
          if (out_data.best_rounded !== exp_res.best_rounded) begin
            $error("best_rounded expected %h got %h", exp_res.best_rounded,
                   out_data.best_rounded);
            n_errors++;
          end
          if (out_data.sum_rounded !== exp_res.sum_rounded) begin
            $error("sum_rounded expected %h got %h", exp_res.sum_rounded,
                   out_data.sum_rounded);
            n_errors++;
          end
          if (out_data.invalid_seen !== exp_res.invalid_seen) begin
            $error("invalid_seen expected %b got %b", exp_res.invalid_seen,
                   out_data.invalid_seen);
            n_errors++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 0);
        2: out_ready <= ($urandom_range(0, 9) == 0);
        default: out_ready <= ((cycles % 37) > 20);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYC) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               awaited_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_item(logic [63:0] v, logic f);
    in_item_t it;
    it.value = v;
    it.first = f;
    if (f) n_seqs++;
    if (v[62:52] == EXP_ALL_ONES) n_nonfin++;
    pending_items.push_back(it);
  endtask

  initial begin
    int len;
    // Directed part: zeros, extremes, rounding overflow, non-finites,
    // a round-half-to-even tie and a sequence that never beats zero.
    add_item(64'h0000_0000_0000_0000, 1'b1);
    add_item(64'h8000_0000_0000_0000, 1'b0);
    add_item(64'h0000_0000_0000_0001, 1'b0);
    add_item(64'h8000_0000_0000_0001, 1'b0);
    add_item(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    add_item(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    add_item(64'hFFEF_FFFF_FFFF_FFFF, 1'b0);
    add_item(64'hFFEF_FFFF_FFFF_FFFF, 1'b0);
    add_item(64'h7FF0_0000_0000_0000, 1'b0);
    add_item(64'h7FF8_0000_0000_0001, 1'b0);
    add_item(64'hFFF0_0000_0000_0000, 1'b0);
    add_item(64'h3FF0_0000_0000_0000, 1'b1);
    add_item(64'h3CA0_0000_0000_0000, 1'b0);
    add_item(64'h0000_0000_0000_0001, 1'b0);
    add_item(64'hC000_0000_0000_0000, 1'b0);
    add_item(64'h000F_FFFF_FFFF_FFFF, 1'b0);
    add_item(64'h0010_0000_0000_0000, 1'b0);
    add_item(64'hBFF0_0000_0000_0000, 1'b1);
    add_item(64'hBFF0_0000_0000_0000, 1'b0);
    add_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_item(64'h3FF0_0000_0000_0000, 1'b0);
    // Random part: sequences of random length with random content; now and
    // then an item restarts a sequence mid-way.
    while (pending_items.size() < 1650) begin
      len = $urandom_range(1, 40);
      add_item(random_double(), 1'b1);
      for (int k = 1; k < len; k++) add_item(random_double(), $urandom_range(0, 49) == 0);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_items.size() > 0 || in_valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Checked %0d results over %0d sequences, %0d non-finite items.",
             n_results, n_seqs, n_nonfin);
    if (n_errors == 0 && awaited_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/msp_pkg.sv
sv/msp_scan.sv
sv/msp_norm.sv
sv/msp_datapath.sv
sv/msp_ctrl.sv
sv/exact_max_prefix_sum_unit.sv
tb/tb.sv
